// ===== hdl/buddy_order_free_list_unit_assert.svh =====
// Assertion macros for the buddy order free list unit.
// Used by the top level only; has no other dependencies.
`ifndef BUDDY_ORDER_FREE_LIST_UNIT_ASSERT_SVH
`define BUDDY_ORDER_FREE_LIST_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define BOFL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bofl assertion failed");
// Next-cycle implication, disabled while reset is low.
`define BOFL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bofl assertion failed");
`else
`define BOFL_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BOFL_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== hdl/bofl_pkg.sv =====
// Shared constants, types and codes of the buddy order free list unit.
// No dependencies.
package bofl_pkg;

  localparam int MAX_HOLES = 16;
  localparam int ADDR_BITS = 10;
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);
  localparam int IDX_W     = $clog2(MAX_HOLES);
  localparam int SLOT_W    = 4;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ADDR_BITS:0]   wide_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [ST_W-1:0]      status_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_TAKE   = 2'd2;
  localparam cmd_t CMD_FIND   = 2'd3;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_FULL   = 3'd1;
  localparam status_t ST_EMPTY  = 3'd2;
  localparam status_t ST_ABSENT = 3'd3;
  localparam status_t ST_NOPAIR = 3'd4;

  // One-hot row operation for the current cycle (all low means hold).
  typedef struct packed {
    logic ins;
    logic rem;
    logic take;
    logic load;
    logic scan;
  } row_ctrl_t;

  typedef struct packed {
    status_t status;
    addr_t   result_address;
    cnt_t    hole_count;
  } res_t;

endpackage

// ===== hdl/bofl_if.sv =====
// Handshake channel interfaces of the buddy order free list unit.
// Depends on bofl_pkg.
interface bofl_in_if;
  import bofl_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  addr_t address;
  modport source (output valid, cmd, address, input ready);
  modport sink (input valid, cmd, address, output ready);
endinterface

interface bofl_out_if;
  import bofl_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  addr_t   result_address;
  cnt_t    hole_count;
  modport source (output valid, status, result_address, hole_count, input ready);
  modport sink (input valid, status, result_address, hole_count, output ready);
endinterface

// ===== hdl/bofl_cell.sv =====
// One cell of the sorted hole row: a held address plus a shadow copy used
// by the buddy sweep. Depends on bofl_pkg.
module bofl_cell (
  input  logic                clk,
  input  bofl_pkg::row_ctrl_t ctrl,
  input  bofl_pkg::addr_t     key,
  input  bofl_pkg::wide_t     size,
  input  bofl_pkg::wide_t     mask,
  input  logic                pair_ok,
  input  logic                held,
  input  logic                prev_ge,
  input  bofl_pkg::addr_t     prev_val,
  input  bofl_pkg::addr_t     next_val,
  input  logic                next_held,
  input  bofl_pkg::addr_t     next_sh,
  input  logic                next_shv,
  output bofl_pkg::addr_t     val,
  output logic                ge,
  output logic                match,
  output bofl_pkg::addr_t     sh,
  output logic                shv,
  output logic                hit
);
  import bofl_pkg::*;

  addr_t val_r, val_nxt;
  wide_t probe_r, probe_nxt;
  logic  cand_r, cand_nxt;
  addr_t sh_r, sh_nxt;
  logic  shv_r, shv_nxt;
  logic  hit_r, hit_nxt;

  always_comb begin
    ge    = !held || (val_r > key);
    match = held && (val_r == key);

    val_nxt = val_r;
    if (ctrl.ins) begin
      if (prev_ge) begin
        val_nxt = prev_val;
      end else if (ge) begin
        val_nxt = key;
      end
    end else if (ctrl.rem) begin
      if (held && (val_r >= key)) begin
        val_nxt = next_val;
      end
    end else if (ctrl.take) begin
      val_nxt = next_val;
    end

    probe_nxt = probe_r;
    cand_nxt  = cand_r;
    sh_nxt    = sh_r;
    shv_nxt   = shv_r;
    hit_nxt   = hit_r;
    if (ctrl.load) begin
      probe_nxt = {1'b0, val_r} + size;
      cand_nxt  = held && pair_ok && (({1'b0, val_r} & mask) == '0);
      sh_nxt    = next_val;
      shv_nxt   = next_held;
      hit_nxt   = 1'b0;
    end else if (ctrl.scan) begin
      hit_nxt = hit_r || (cand_r && shv_r && ({1'b0, sh_r} == probe_r));
      sh_nxt  = next_sh;
      shv_nxt = next_shv;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    probe_r <= probe_nxt;
    cand_r  <= cand_nxt;
    sh_r    <= sh_nxt;
    shv_r   <= shv_nxt;
    hit_r   <= hit_nxt;
  end

  assign val = val_r;
  assign sh  = sh_r;
  assign shv = shv_r;
  assign hit = hit_r;

endmodule

// ===== hdl/bofl_row.sv =====
// Row of MAX_HOLES cells with neighbor wiring and the lowest-hit select.
// Depends on bofl_pkg and bofl_cell.
module bofl_row (
  input  logic                           clk,
  input  bofl_pkg::row_ctrl_t            ctrl,
  input  bofl_pkg::addr_t                key,
  input  bofl_pkg::wide_t                size,
  input  bofl_pkg::wide_t                mask,
  input  logic                           pair_ok,
  input  logic [bofl_pkg::MAX_HOLES-1:0] held,
  output bofl_pkg::addr_t                first_addr,
  output logic                           match_any,
  output logic                           pair_found,
  output bofl_pkg::addr_t                pair_addr
);
  import bofl_pkg::*;

  addr_t                val_w [MAX_HOLES];
  addr_t                sh_w  [MAX_HOLES];
  logic [MAX_HOLES-1:0] ge_w;
  logic [MAX_HOLES-1:0] match_w;
  logic [MAX_HOLES-1:0] shv_w;
  logic [MAX_HOLES-1:0] hit_w;

  for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
    logic  prev_ge_c;
    addr_t prev_val_c;
    addr_t next_val_c;
    logic  next_held_c;
    addr_t next_sh_c;
    logic  next_shv_c;

    if (i == 0) begin : g_first
      assign prev_ge_c  = 1'b0;
      assign prev_val_c = val_w[i];
    end else begin : g_mid
      assign prev_ge_c  = ge_w[i-1];
      assign prev_val_c = val_w[i-1];
    end

    if (i == MAX_HOLES - 1) begin : g_last
      assign next_val_c  = val_w[i];
      assign next_held_c = 1'b0;
      assign next_sh_c   = sh_w[i];
      assign next_shv_c  = 1'b0;
    end else begin : g_body
      assign next_val_c  = val_w[i+1];
      assign next_held_c = held[i+1];
      assign next_sh_c   = sh_w[i+1];
      assign next_shv_c  = shv_w[i+1];
    end

    bofl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key),
      .size      (size),
      .mask      (mask),
      .pair_ok   (pair_ok),
      .held      (held[i]),
      .prev_ge   (prev_ge_c),
      .prev_val  (prev_val_c),
      .next_val  (next_val_c),
      .next_held (next_held_c),
      .next_sh   (next_sh_c),
      .next_shv  (next_shv_c),
      .val       (val_w[i]),
      .ge        (ge_w[i]),
      .match     (match_w[i]),
      .sh        (sh_w[i]),
      .shv       (shv_w[i]),
      .hit       (hit_w[i])
    );
  end

  assign first_addr = val_w[0];
  assign match_any  = |match_w;

  // The row is sorted, so the lowest cell with a hit holds the lowest pair.
  always_comb begin
    pair_found = 1'b0;
    pair_addr  = '0;
    for (int i = MAX_HOLES - 1; i >= 0; i--) begin
      if (hit_w[i]) begin
        pair_found = 1'b1;
        pair_addr  = val_w[i];
      end
    end
  end

endmodule

// ===== hdl/buddy_order_free_list_unit.sv =====
// Top level of the buddy order free list unit: control, result buffering.
// Depends on bofl_pkg, bofl_if, bofl_row and the assertion header.
//
// The unit keeps the free holes of one buddy order as an ascending sorted
// multiset of up to MAX_HOLES (16) start addresses, held in a row of cells.
// Add, remove and take-lowest transactions are accepted one per cycle while
// the unit is idle and no result is pending: every cell looks at its
// neighbors and shifts, so each update keeps the row sorted. During a
// find-buddy-pair transaction a shadow copy of the row sweeps one cell per
// cycle past every cell, and each cell records whether its aligned address
// plus the slot size went by; the done state then picks the lowest hit. The
// sweep length is what sets the find latency. Results leave through an
// output register backed by one pending slot, so a new transaction is still
// accepted while one finished result waits to be taken. slot_order is
// written through cfg_wr_en and cfg_wr_data, by the user only while the unit
// is idle (not enforced by the unit); it resets to 3. The store starts empty.
`include "buddy_order_free_list_unit_assert.svh"
module buddy_order_free_list_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bofl_pkg::SLOT_W-1:0]   cfg_wr_data,
  bofl_in_if.sink                       in_chan,
  bofl_out_if.source                    out_chan
);
  import bofl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  slot_t                slot_order_r, slot_order_nxt;
  cnt_t                 held_cnt_r, held_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  res_t                 pend_res_r, pend_res_nxt;

  logic                 in_acc;
  logic                 out_free;
  row_ctrl_t            ctrl;
  logic                 res_valid;
  res_t                 res;
  logic [MAX_HOLES-1:0] held;
  wide_t                size;
  wide_t                mask;
  logic                 pair_ok;
  addr_t                first_addr;
  logic                 match_any;
  logic                 pair_found;
  addr_t                pair_addr;

  assign in_chan.ready = (state_r == S_IDLE) && !pend_valid_r;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // A slot order at or beyond the address width leaves no room for a buddy.
  assign pair_ok = int'(slot_order_r) < ADDR_BITS;
  assign size    = wide_t'(1) << slot_order_r;
  assign mask    = (size << 1) - wide_t'(1);

  always_comb begin
    for (int i = 0; i < MAX_HOLES; i++) begin
      held[i] = CNT_W'(i) < held_cnt_r;
    end
  end

  bofl_row u_row (
    .clk        (clk),
    .ctrl       (ctrl),
    .key        (in_chan.address),
    .size       (size),
    .mask       (mask),
    .pair_ok    (pair_ok),
    .held       (held),
    .first_addr (first_addr),
    .match_any  (match_any),
    .pair_found (pair_found),
    .pair_addr  (pair_addr)
  );

  // Command decode and the sequencer for the buddy sweep.
  always_comb begin
    ctrl          = '0;
    res_valid     = 1'b0;
    res           = '0;
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    held_cnt_nxt  = held_cnt_r;

    case (state_r)
      S_IDLE: begin
        res.hole_count = held_cnt_r;
        if (in_acc) begin
          res_valid = 1'b1;
          case (in_chan.cmd)
            CMD_ADD: begin
              if (held_cnt_r == CNT_W'(MAX_HOLES)) begin
                res.status = ST_FULL;
              end else begin
                ctrl.ins     = 1'b1;
                held_cnt_nxt = held_cnt_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (match_any) begin
                ctrl.rem     = 1'b1;
                held_cnt_nxt = held_cnt_r - CNT_W'(1);
              end else begin
                res.status = ST_ABSENT;
              end
            end
            CMD_TAKE: begin
              if (held_cnt_r == '0) begin
                res.status = ST_EMPTY;
              end else begin
                ctrl.take          = 1'b1;
                res.result_address = first_addr;
                held_cnt_nxt       = held_cnt_r - CNT_W'(1);
              end
            end
            CMD_FIND: begin
              res_valid    = 1'b0;
              ctrl.load    = 1'b1;
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN;
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
          res.hole_count = held_cnt_nxt;
        end
      end
      S_SCAN: begin
        ctrl.scan    = 1'b1;
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        if (scan_cnt_r == IDX_W'(MAX_HOLES - 2)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid          = 1'b1;
        res.status         = pair_found ? ST_OK : ST_NOPAIR;
        res.result_address = pair_found ? pair_addr : '0;
        res.hole_count     = held_cnt_r;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register with one pending slot behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = res_valid;
        pend_res_nxt   = res;
      end else begin
        out_valid_nxt = res_valid;
        out_res_nxt   = res;
      end
    end else if (res_valid) begin
      pend_valid_nxt = 1'b1;
      pend_res_nxt   = res;
    end
  end

  assign slot_order_nxt = cfg_wr_en ? cfg_wr_data : slot_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      slot_order_r <= SLOT_W'(3);
      held_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      slot_order_r <= slot_order_nxt;
      held_cnt_r   <= held_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_res_r.status;
  assign out_chan.result_address = out_res_r.result_address;
  assign out_chan.hole_count     = out_res_r.hole_count;

  // The hole count never passes the row length.
  `BOFL_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, held_cnt_r <= CNT_W'(MAX_HOLES))
  // A waiting pending result always has a full output register ahead of it.
  `BOFL_ASSERT_IMP(a_pend_order, clk, rst_n, pend_valid_r, out_valid_r)
  // An accepted add into a store with room grows the count by one.
  `BOFL_ASSERT_NXT(a_add_grows, clk, rst_n, in_acc && (in_chan.cmd == CMD_ADD) && (held_cnt_r != CNT_W'(MAX_HOLES)), held_cnt_r == $past(held_cnt_r) + CNT_W'(1))
  // A find transaction never changes the hole count.
  `BOFL_ASSERT_NXT(a_find_keeps, clk, rst_n, state_r != S_IDLE, held_cnt_r == $past(held_cnt_r))

endmodule
